// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants, codes and bundle types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  // list geometry
  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // request field widths
  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int OCC_W = 6;
  localparam int ST_W  = 2;

  // width used for position against count compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // width used when widening a stored element to the result field
  localparam int WIDE_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // shift command broadcast to every cell of the row
  typedef struct packed {
    logic                  ins;
    logic                  del;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  // per-request result fields from the controller
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             removed_valid;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// ===== design/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one storage slot of the list row, shifts toward head or tail on command
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                               clk,
  input  ple_pkg::cmd_t                      cmd,
  input  logic [ple_pkg::IDX_W-1:0]          slot,
  input  logic [ple_pkg::DATA_WIDTH-1:0]     left,
  input  logic [ple_pkg::DATA_WIDTH-1:0]     right,
  output logic [ple_pkg::DATA_WIDTH-1:0]     data,
  output logic [ple_pkg::DATA_WIDTH-1:0]     hit_data
);

  logic at_idx;
  logic past_idx;

  assign at_idx   = (slot == cmd.idx);
  assign past_idx = (slot > cmd.idx);

  // insert opens a gap at idx, delete closes it
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (past_idx) begin
        data <= left;
      end else if (at_idx) begin
        data <= cmd.value;
      end
    end else if (cmd.del) begin
      if (past_idx || at_idx) begin
        data <= right;
      end
    end
  end

  // contents of the addressed slot, zero elsewhere
  assign hit_data = at_idx ? data : '0;

endmodule

// ===== design/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// request decode, range checks and element count of the list
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [ple_pkg::REQ_W-1:0]           req_type,
  input  logic signed [ple_pkg::VAL_W-1:0]    value,
  input  logic [ple_pkg::POS_W-1:0]           position,
  output ple_pkg::cmd_t                       cmd,
  output ple_pkg::res_t                       res
);

  logic [ple_pkg::CNT_W-1:0] length;
  logic [ple_pkg::CNT_W-1:0] length_next;
  logic [ple_pkg::CMP_W-1:0] len_c;
  logic [ple_pkg::CMP_W-1:0] pos_c;
  logic [ple_pkg::CMP_W-1:0] pos_m1;
  logic                      pos_bad;
  logic                      full;
  logic                      empty;
  logic [ple_pkg::ST_W-1:0]  status;
  logic                      do_ins;
  logic                      do_del;
  logic [ple_pkg::IDX_W-1:0] idx;

  assign len_c   = ple_pkg::CMP_W'(length);
  assign pos_c   = ple_pkg::CMP_W'(position);
  assign pos_m1  = pos_c - 1'b1;
  assign pos_bad = (pos_c == '0) || (pos_c > len_c);
  assign full    = (length >= ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty   = (length == '0);

  // decode request into status and shift command
  always_comb begin
    status = ple_pkg::ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    case (req_type)
      ple_pkg::REQ_INS_HEAD: begin
        if (full) status = ple_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ple_pkg::REQ_INS_TAIL: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = length[ple_pkg::IDX_W-1:0];
        end
      end
      ple_pkg::REQ_INS_POS: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else if (pos_bad) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          do_ins = 1'b1;
          idx    = pos_m1[ple_pkg::IDX_W-1:0];
        end
      end
      ple_pkg::REQ_DEL_HEAD: begin
        if (empty) status = ple_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      ple_pkg::REQ_DEL_TAIL: begin
        if (empty) begin
          status = ple_pkg::ST_EMPTY;
        end else begin
          do_del = 1'b1;
          idx    = ple_pkg::IDX_W'(length - 1'b1);
        end
      end
      ple_pkg::REQ_DEL_POS: begin
        if (empty) begin
          status = ple_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          status = ple_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
          idx    = pos_m1[ple_pkg::IDX_W-1:0];
        end
      end
      default: status = ple_pkg::ST_RANGE;
    endcase
  end

  // count after this request
  always_comb begin
    length_next = length;
    if (do_ins) length_next = length + 1'b1;
    else if (do_del) length_next = length - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (accept) begin
      length <= length_next;
    end
  end

  assign cmd.ins   = accept && do_ins;
  assign cmd.del   = accept && do_del;
  assign cmd.idx   = idx;
  assign cmd.value = ple_pkg::DATA_WIDTH'(value);

  assign res.status        = status;
  assign res.removed_valid = do_del;
  assign res.count         = length_next;

  // count stays within the row
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("list count beyond capacity");

  // a rejected request leaves the count alone
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (status != ple_pkg::ST_OK) |=> length == $past(length))
    else $error("rejected request changed count");

  // only one of insert and delete at a time
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.del))
    else $error("insert and delete together");

endmodule

// ===== design/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// an accepted request's result is loaded into the result register at the accepting edge
// throughput: one request per cycle while results are taken, the whole row of cells shifts at the same edge
// a stalled result blocks new requests until it is taken
// reset clears the count and result valid, cell contents are left as they are
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[2:0], value[34:3], position[40:35], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], removed_valid[2], removed_value[34:3], occupancy[40:35], zero fill
  output logic [47:0] m_tdata
);

  localparam int N = ple_pkg::CAPACITY;
  localparam int W = ple_pkg::DATA_WIDTH;

  logic                             accept;
  logic [ple_pkg::REQ_W-1:0]        req_type;
  logic signed [ple_pkg::VAL_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]        position;
  ple_pkg::cmd_t                    cmd;
  ple_pkg::res_t                    res;

  logic [W-1:0] cell_data [N];
  logic [W-1:0] cell_hit  [N];
  logic [W-1:0] removed_sel;
  logic signed [ple_pkg::WIDE_W-1:0] removed_wide;

  logic [ple_pkg::ST_W-1:0]  status;
  logic                      removed_valid;
  logic [ple_pkg::VAL_W-1:0] removed_value;
  logic [ple_pkg::OCC_W-1:0] occupancy;

  // unpack request
  assign req_type = s_tdata[2:0];
  assign value    = s_tdata[34:3];
  assign position = s_tdata[40:35];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_type),
    .value    (value),
    .position (position),
    .cmd      (cmd),
    .res      (res)
  );

  // row of cells, each neighbor feeds the next
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left;
    logic [W-1:0] right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .slot     (ple_pkg::IDX_W'(i)),
      .left     (left),
      .right    (right),
      .data     (cell_data[i]),
      .hit_data (cell_hit[i])
    );
  end

  // gather the addressed slot before it shifts
  always_comb begin
    removed_sel = '0;
    for (int k = 0; k < N; k++) begin
      removed_sel = removed_sel | cell_hit[k];
    end
  end

  assign removed_wide = ple_pkg::WIDE_W'($signed(removed_sel));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res.status;
      removed_valid <= res.removed_valid;
      removed_value <= res.removed_valid ? removed_wide[ple_pkg::VAL_W-1:0] : '0;
      occupancy     <= ple_pkg::OCC_W'(res.count);
    end
  end

  assign m_tdata = {7'd0, occupancy, removed_value, removed_valid, status};

  // a removed element only comes with a good status
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && removed_valid |-> status == ple_pkg::ST_OK)
    else $error("removed element with failing status");

  // no removed element means a zero value field
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !removed_valid |-> removed_value == '0)
    else $error("stray removed value");

  // a good insert leaves the list nonempty
  a_ins_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ple_pkg::ST_OK) && !removed_valid |-> occupancy != '0)
    else $error("successful insert with empty list");

endmodule

// ===== tb/positional_list_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// self-checking bench for the positional list engine: requests stream in with
// random gaps, results are drained under random backpressure, and each result
// is compared against an in-bench list model kept in a queue
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 1230;
  localparam int MAX_REPORTS  = 10;

  // one request waiting to be driven, with its idle mode
  typedef struct {
    logic [47:0] word;
    bit          calm;
  } pending_req_t;

  // one expected result
  typedef struct packed {
    logic [ple_pkg::ST_W-1:0]  status;
    logic                      removed_valid;
    logic [ple_pkg::VAL_W-1:0] removed_value;
    logic [ple_pkg::OCC_W-1:0] occupancy;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  pending_req_t                   pending_reqs[$];
  list_result_t                   expected_results[$];
  logic [ple_pkg::DATA_WIDTH-1:0] list_cells[$];

  int  errors = 0;
  int  cycles = 0;
  int  idle_gap = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  int  gen_len = 0;

  positional_list_engine_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always #2 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one request to the list model and return its result
  function automatic list_result_t apply_request(logic [47:0] word);
    logic [ple_pkg::REQ_W-1:0]      kind;
    logic [ple_pkg::VAL_W-1:0]      val;
    logic [ple_pkg::POS_W-1:0]      pos;
    logic [63:0]                    ext;
    logic [ple_pkg::DATA_WIDTH-1:0] elem;
    list_result_t                   r;
    int                             len;
    int                             idx;
    kind = word[2:0];
    val  = word[34:3];
    pos  = word[40:35];
    r    = '0;
    len  = list_cells.size();
    idx  = -1;
    ext  = 64'(signed'(val));
    elem = ext[ple_pkg::DATA_WIDTH-1:0];
    case (kind)
      ple_pkg::REQ_INS_HEAD, ple_pkg::REQ_INS_TAIL, ple_pkg::REQ_INS_POS: begin
        if (len >= ple_pkg::CAPACITY) r.status = ple_pkg::ST_FULL;
        else if (kind == ple_pkg::REQ_INS_HEAD) idx = 0;
        else if (kind == ple_pkg::REQ_INS_TAIL) idx = len;
        else if (pos == 0 || pos > len) r.status = ple_pkg::ST_RANGE;
        else idx = pos - 1;
        if (idx >= 0) list_cells.insert(idx, elem);
      end
      ple_pkg::REQ_DEL_HEAD, ple_pkg::REQ_DEL_TAIL, ple_pkg::REQ_DEL_POS: begin
        if (len == 0) r.status = ple_pkg::ST_EMPTY;
        else if (kind == ple_pkg::REQ_DEL_HEAD) idx = 0;
        else if (kind == ple_pkg::REQ_DEL_TAIL) idx = len - 1;
        else if (pos == 0 || pos > len) r.status = ple_pkg::ST_RANGE;
        else idx = pos - 1;
        if (idx >= 0) begin
          elem = list_cells[idx];
          list_cells.delete(idx);
          ext = 64'(signed'(elem));
          r.removed_valid = 1'b1;
          r.removed_value = ext[ple_pkg::VAL_W-1:0];
        end
      end
      default: r.status = ple_pkg::ST_RANGE;
    endcase
    r.occupancy = ple_pkg::OCC_W'(list_cells.size());
    return r;
  endfunction

  // queue a request and track the count it leaves behind
  task automatic push_req(logic [ple_pkg::REQ_W-1:0] kind, logic [ple_pkg::VAL_W-1:0] val,
                          logic [ple_pkg::POS_W-1:0] pos, bit quiet);
    pending_req_t p;
    p.word = {7'b0, pos, val, kind};
    p.calm = quiet;
    pending_reqs.push_back(p);
    case (kind)
      ple_pkg::REQ_INS_HEAD, ple_pkg::REQ_INS_TAIL:
        if (gen_len < ple_pkg::CAPACITY) gen_len++;
      ple_pkg::REQ_INS_POS:
        if (gen_len < ple_pkg::CAPACITY && pos >= 1 && pos <= gen_len) gen_len++;
      ple_pkg::REQ_DEL_HEAD, ple_pkg::REQ_DEL_TAIL:
        if (gen_len > 0) gen_len--;
      ple_pkg::REQ_DEL_POS:
        if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // random request with a chosen insert share
  task automatic push_random(int ins_pct, bit quiet);
    logic [ple_pkg::REQ_W-1:0] kind;
    logic [ple_pkg::VAL_W-1:0] val;
    logic [ple_pkg::POS_W-1:0] pos;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      kind = ple_pkg::REQ_W'($urandom_range(6, 7));
    end else if (r < 2 + ins_pct) begin
      kind = ple_pkg::REQ_W'($urandom_range(ple_pkg::REQ_INS_HEAD, ple_pkg::REQ_INS_POS));
    end else begin
      kind = ple_pkg::REQ_W'($urandom_range(ple_pkg::REQ_DEL_HEAD, ple_pkg::REQ_DEL_POS));
    end
    r = $urandom_range(0, 99);
    if (r < 80 && gen_len > 0) pos = ple_pkg::POS_W'($urandom_range(1, gen_len));
    else if (r < 87) pos = '0;
    else if (r < 93) pos = ple_pkg::POS_W'(gen_len + 1);
    else pos = ple_pkg::POS_W'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 85) val = $urandom;
    else if (r < 90) val = 32'h8000_0000;
    else if (r < 95) val = 32'h7fff_ffff;
    else val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    push_req(kind, val, pos, quiet);
  endtask

  // driver: one request in flight, random gaps between requests unless the request is calm
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      idle_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(apply_request(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (idle_gap > 0) begin
          idle_gap <= idle_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          pending_req_t p;
          p = pending_reqs.pop_front();
          s_tdata  <= p.word;
          s_tvalid <= 1'b1;
          calm     <= p.calm;
          idle_gap <= p.calm ? 0 : draw_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls on the result side unless calm, compare each result
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        list_result_t got;
        list_result_t want;
        got = {m_tdata[1:0], m_tdata[2], m_tdata[34:3], m_tdata[40:35]};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: status %0d removed %0d/%0h occupancy %0d",
                     got.status, got.removed_valid, got.removed_value, got.occupancy);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status || got.removed_valid != want.removed_valid ||
              got.removed_value != want.removed_value ||
              got.occupancy != want.occupancy) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: expected st %0d rv %0d val %08h occ %0d,",
                       want.status, want.removed_valid, want.removed_value, want.occupancy,
                       " got st %0d rv %0d val %08h occ %0d",
                       got.status, got.removed_valid, got.removed_value, got.occupancy);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left <= draw_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int issued;
    int seg_len;
    int ins_pct;
    bit quiet;

    // empty-list cases and unknown request types
    push_req(ple_pkg::REQ_DEL_HEAD, 32'h1234_5678, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_DEL_TAIL, 32'h0, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd1, 1'b0);
    push_req(ple_pkg::REQ_INS_POS, 32'h1111_1111, 6'd1, 1'b0);
    push_req(3'd6, 32'hffff_ffff, 6'd63, 1'b0);
    push_req(3'd7, 32'h0, 6'd1, 1'b0);
    // value extremes through each insert kind
    push_req(ple_pkg::REQ_INS_HEAD, 32'h7fff_ffff, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_INS_TAIL, 32'h8000_0000, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_INS_POS, 32'h0, 6'd1, 1'b0);
    push_req(ple_pkg::REQ_INS_POS, 32'hffff_ffff, 6'd3, 1'b0);
    // positions out of range
    push_req(ple_pkg::REQ_INS_POS, 32'h2222_2222, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_INS_POS, 32'h2222_2222, 6'd5, 1'b0);
    push_req(ple_pkg::REQ_INS_POS, 32'h2222_2222, 6'd63, 1'b0);
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd5, 1'b0);
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd63, 1'b0);
    // each delete kind down to empty
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd2, 1'b0);
    push_req(ple_pkg::REQ_DEL_TAIL, 32'h0, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_DEL_HEAD, 32'h0, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_DEL_POS, 32'h0, 6'd1, 1'b0);
    push_req(ple_pkg::REQ_INS_TAIL, 32'h5555_5555, 6'd0, 1'b0);
    push_req(ple_pkg::REQ_INS_HEAD, 32'haaaa_aaaa, 6'd0, 1'b0);

    // random segments that swing between full and empty
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      if (seg_len > RANDOM_ITEMS - issued) seg_len = RANDOM_ITEMS - issued;
      case ($urandom_range(0, 2))
        0: ins_pct = 80;
        1: ins_pct = 18;
        default: ins_pct = 49;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat (seg_len) push_random(ins_pct, quiet);
      issued += seg_len;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // drain everything, sampled away from the active edge
    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
